// ----- rtl/least_loaded_worker_select_defines.svh -----
// Assertion macros shared by the worker selector RTL.
`ifndef LEAST_LOADED_WORKER_SELECT_DEFINES_SVH
`define LEAST_LOADED_WORKER_SELECT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LLWS_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LLWS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/llws_pkg.sv -----
// Types and constants for the least loaded worker selector.
`default_nettype none
package llws_pkg;

  localparam int CMD_W    = 2;
  localparam int WORKER_W = 4;
  localparam int LOAD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int WC_W     = 5;
  localparam int CAP_W    = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [WC_W-1:0]   WC_RESET  = 5'd16;
  localparam logic [CAP_W-1:0]  CAP_RESET = 32'd1024;
  localparam logic [LOAD_W-1:0] LOAD_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_PICK   = 2'd0,
    CMD_ACCEPT = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_RANGE      = 2'd2,
    ST_IDLE_CLOSE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORKER_COUNT = 1'b0,
    REG_CAPACITY     = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ALU_LT  = 2'd0,
    ALU_INC = 2'd1,
    ALU_DEC = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic lt;
    logic zero;
  } alu_flags_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_CAP  = 5'b00100,
    S_UPD  = 5'b01000,
    S_RES  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/llws_in_if.sv -----
// Command channel: valid/ready plus command and worker index.
`default_nettype none
interface llws_in_if
  import llws_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [WORKER_W-1:0] worker;

  modport source (output valid, output command, output worker, input ready);
  modport sink   (input valid, input command, input worker, output ready);
endinterface
`default_nettype wire

// ----- rtl/llws_out_if.sv -----
// Result channel: valid/ready plus target worker, load and status.
`default_nettype none
interface llws_out_if
  import llws_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [WORKER_W-1:0] target_worker;
  logic [LOAD_W-1:0]   load;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output target_worker, output load, output status,
                  input ready);
  modport sink   (input valid, input target_worker, input load, input status,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/llws_count_mem.sv -----
// Per-worker connection count store: one write port, one registered read port.
`default_nettype none
module llws_count_mem
  import llws_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int COUNT_WIDTH = 32,
  parameter int IDX_W       = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   we,
  input  wire logic [IDX_W-1:0]       waddr,
  input  wire logic [COUNT_WIDTH-1:0] wdata,
  input  wire logic [IDX_W-1:0]       raddr,
  output      logic [COUNT_WIDTH-1:0] rdata
);

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       vld_r;
  logic [COUNT_WIDTH-1:0] rd_r;
  logic                   rv_r;

  // valid bits stand in for a clear: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rv_r <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  assign rdata = rv_r ? rd_r : '0;

endmodule
`default_nettype wire

// ----- rtl/llws_alu.sv -----
// Shared compare / saturating increment / decrement unit.
`default_nettype none
module llws_alu
  import llws_pkg::*;
#(
  parameter  int COUNT_WIDTH = 32,
  localparam int AW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32
) (
  input  wire alu_op_t                op,
  input  wire logic [AW-1:0]          a,
  input  wire logic [AW-1:0]          b,
  output      logic [COUNT_WIDTH-1:0] res,
  output      alu_flags_t             flags
);

  logic [COUNT_WIDTH-1:0] a_c;

  assign a_c        = a[COUNT_WIDTH-1:0];
  assign flags.lt   = (a < b);
  assign flags.zero = (a == '0);

  always_comb begin
    unique case (op)
      ALU_INC: res = (a_c == '1) ? a_c : a_c + 1'b1;
      ALU_DEC: res = a_c - 1'b1;
      ALU_LT:  res = a_c;
      default: res = a_c;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/least_loaded_worker_select.sv -----
// Top level of the least loaded worker selector.
// Keeps one active-connection count per worker. An accept beat bumps a worker's
// count (saturating), a close beat drops it, and a pick beat returns the
// lowest-numbered worker with the smallest count among the first worker_count
// workers (zero counts as one, MAX_WORKERS at most), flagged server full when
// that count reaches capacity. Items are handled one at a time; in_ch.ready is
// high only while the sequencer idles. The pick scan reads one count per cycle
// through the single read port of the count store and one shared comparator,
// then S_CAP checks capacity and S_RES loads the result. Accept and close go
// through S_UPD (update through the shared unit) and S_RES; an out-of-range or
// unused command goes straight to S_RES. The input reopens as the result is
// loaded. A new beat is taken while a finished result still waits in the output
// register; a second result that cannot be loaded holds the sequencer until the
// output register frees up. Counts reset to zero through per-entry valid bits,
// so there is no clearing pass after reset.
`default_nettype none
module least_loaded_worker_select
  import llws_pkg::*;
#(
  parameter int MAX_WORKERS = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  llws_in_if.sink                   in_ch,
  llws_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

`include "least_loaded_worker_select_defines.svh"

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int AW    = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  function automatic logic [LOAD_W-1:0] load_sat(input logic [AW-1:0] v);
    if (v > AW'(LOAD_MAX)) begin
      return LOAD_MAX;
    end
    return v[LOAD_W-1:0];
  endfunction

  // configuration
  logic [WC_W-1:0]  wc_r;
  logic [CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r  <= WC_RESET;
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WORKER_COUNT: wc_r  <= cfg_wdata[WC_W-1:0];
        REG_CAPACITY:     cap_r <= cfg_wdata[CAP_W-1:0];
      endcase
    end
  end

  // highest worker index taking part
  logic [IDX_W-1:0] last_idx;

  always_comb begin
    priority if (wc_r == '0) begin
      last_idx = '0;
    end else if (32'(wc_r) > MAX_WORKERS) begin
      last_idx = IDX_W'(MAX_WORKERS - 1);
    end else begin
      last_idx = IDX_W'(wc_r - 5'd1);
    end
  end

  // sequencer state
  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [WORKER_W-1:0]  wk_r, wk_nxt;
  logic [IDX_W-1:0]     widx_r, widx_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]     best_r, best_nxt;
  logic [COUNT_WIDTH-1:0] cur_r, cur_nxt;
  logic [WORKER_W-1:0]  res_tgt_r, res_tgt_nxt;
  logic [LOAD_W-1:0]    res_load_r, res_load_nxt;
  status_t              res_st_r, res_st_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORKER_W-1:0]  out_tgt_r, out_tgt_nxt;
  logic [LOAD_W-1:0]    out_load_r, out_load_nxt;
  logic [STATUS_W-1:0]  out_st_r, out_st_nxt;

  // datapath links
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_rdata;
  alu_op_t                alu_op;
  logic [AW-1:0]          alu_a, alu_b;
  logic [COUNT_WIDTH-1:0] alu_res;
  alu_flags_t             alu_flags;

  logic                 in_fire;
  logic                 out_free;
  logic [31:0]          in_w_ext;
  logic [31:0]          best_ext;
  logic                 in_range;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_w_ext    = 32'(in_ch.worker);
  assign best_ext    = 32'(best_r);
  assign in_range    = (in_w_ext <= 32'(last_idx));

  llws_count_mem #(
    .DEPTH       (MAX_WORKERS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (widx_r),
    .wdata (alu_res),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  llws_alu #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .flags (alu_flags)
  );

  // shared unit operand steering
  always_comb begin
    alu_op = ALU_LT;
    alu_a  = AW'(mem_rdata);
    alu_b  = AW'(cur_r);
    unique case (state_r)
      S_CAP: begin
        alu_a = AW'(cur_r);
        alu_b = AW'(cap_r);
      end
      S_UPD: begin
        alu_op = (cmd_r == CMD_CLOSE) ? ALU_DEC : ALU_INC;
        alu_b  = '0;
      end
      S_IDLE, S_SCAN, S_RES: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    wk_nxt        = wk_r;
    widx_nxt      = widx_r;
    cmp_idx_nxt   = cmp_idx_r;
    best_nxt      = best_r;
    cur_nxt       = cur_r;
    res_tgt_nxt   = res_tgt_r;
    res_load_nxt  = res_load_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_tgt_nxt   = out_tgt_r;
    out_load_nxt  = out_load_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_raddr     = in_w_ext[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (cmd_t'(in_ch.command) == CMD_PICK) begin
          mem_raddr = '0;
        end
        if (in_fire) begin
          cmd_nxt  = cmd_t'(in_ch.command);
          wk_nxt   = in_ch.worker;
          widx_nxt = in_w_ext[IDX_W-1:0];
          unique case (cmd_t'(in_ch.command))
            CMD_PICK: begin
              cmp_idx_nxt = '0;
              state_nxt   = S_SCAN;
            end
            CMD_ACCEPT, CMD_CLOSE: begin
              if (in_range) begin
                state_nxt = S_UPD;
              end else begin
                res_tgt_nxt  = in_ch.worker;
                res_load_nxt = '0;
                res_st_nxt   = ST_RANGE;
                state_nxt    = S_RES;
              end
            end
            CMD_RSVD: begin
              res_tgt_nxt  = in_ch.worker;
              res_load_nxt = '0;
              res_st_nxt   = ST_RANGE;
              state_nxt    = S_RES;
            end
          endcase
        end
      end

      S_SCAN: begin
        // rdata holds the count of worker cmp_idx_r; fetch the next one
        mem_raddr = cmp_idx_r + 1'b1;
        if (cmp_idx_r == '0 || alu_flags.lt) begin
          cur_nxt  = mem_rdata;
          best_nxt = cmp_idx_r;
        end
        if (cmp_idx_r == last_idx) begin
          state_nxt = S_CAP;
        end else begin
          cmp_idx_nxt = cmp_idx_r + 1'b1;
        end
      end

      S_CAP: begin
        res_tgt_nxt  = best_ext[WORKER_W-1:0];
        res_load_nxt = load_sat(AW'(cur_r));
        res_st_nxt   = alu_flags.lt ? ST_OK : ST_FULL;
        state_nxt    = S_RES;
      end

      S_UPD: begin
        res_tgt_nxt = wk_r;
        if (cmd_r == CMD_CLOSE && alu_flags.zero) begin
          res_load_nxt = '0;
          res_st_nxt   = ST_IDLE_CLOSE;
        end else begin
          mem_we       = 1'b1;
          res_load_nxt = load_sat(AW'(alu_res));
          res_st_nxt   = ST_OK;
        end
        state_nxt = S_RES;
      end

      S_RES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tgt_nxt   = res_tgt_r;
          out_load_nxt  = res_load_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    wk_r       <= wk_nxt;
    widx_r     <= widx_nxt;
    best_r     <= best_nxt;
    cur_r      <= cur_nxt;
    res_tgt_r  <= res_tgt_nxt;
    res_load_r <= res_load_nxt;
    res_st_r   <= res_st_nxt;
    out_tgt_r  <= out_tgt_nxt;
    out_load_r <= out_load_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.target_worker = out_tgt_r;
  assign out_ch.load          = out_load_r;
  assign out_ch.status        = out_st_r;

  `LLWS_CHECK_NEXT(a_leave_idle, in_fire, state_r != S_IDLE, "accepted beat did not start work")
  `LLWS_CHECK_NEXT(a_res_loads, state_r == S_RES && out_free, out_valid_r, "result not loaded")
  `LLWS_CHECK(a_we_only_upd, mem_we, state_r == S_UPD && cmd_r != CMD_RSVD, "stray count write")
  `LLWS_CHECK(a_scan_bound, state_r == S_SCAN, cmp_idx_r <= last_idx, "scan ran past last worker")

endmodule
`default_nettype wire

// ----- tb/sv/least_loaded_worker_select_tb.sv -----
// Self-checking testbench for the least loaded worker selector.
module least_loaded_worker_select_tb;
  import llws_pkg::*;

  localparam int MAX_W = 16;
  localparam int COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [WORKER_W-1:0] target;
    logic [LOAD_W-1:0]   load;
    status_t             status;
  } load_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_reg_t             cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  llws_in_if  in_ch ();
  llws_out_if out_ch ();

  least_loaded_worker_select #(
    .MAX_WORKERS (MAX_W),
    .COUNT_WIDTH (COUNT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block's state and registers.
  logic [COUNT_W-1:0] conn_count [MAX_W];
  logic [WC_W-1:0]    wc_cfg;
  logic [CAP_W-1:0]   cap_cfg;

  load_result_t pending_results [$];
  load_result_t head;

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int full_seen = 0;
  int range_seen = 0;
  int idle_close_seen = 0;
  int saturated_seen = 0;
  int sender_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_len = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  function automatic int active_workers();
    if (wc_cfg == 0) return 1;
    if (wc_cfg > MAX_W) return MAX_W;
    return int'(wc_cfg);
  endfunction

  // Applies one command to the shadow counts and returns the result it produces.
  function automatic load_result_t balance_step(input cmd_t cmd,
                                                input logic [WORKER_W-1:0] w);
    load_result_t r;
    int n;
    int best;
    logic [COUNT_W-1:0] low;
    n = active_workers();
    r.target = w;
    r.load = '0;
    r.status = ST_RANGE;
    case (cmd)
      CMD_PICK: begin
        best = 0;
        low = conn_count[0];
        for (int i = 1; i < n; i++) begin
          if (conn_count[i] < low) begin
            low = conn_count[i];
            best = i;
          end
        end
        r.target = best[WORKER_W-1:0];
        r.load = LOAD_W'(low);
        r.status = (LOAD_W'(low) >= cap_cfg) ? ST_FULL : ST_OK;
      end
      CMD_ACCEPT: begin
        if (int'(w) < n) begin
          if (conn_count[w] != COUNT_TOP) conn_count[w] = conn_count[w] + 1'b1;
          r.load = LOAD_W'(conn_count[w]);
          r.status = ST_OK;
        end
      end
      CMD_CLOSE: begin
        if (int'(w) < n) begin
          if (conn_count[w] == '0) begin
            r.status = ST_IDLE_CLOSE;
          end else begin
            conn_count[w] = conn_count[w] - 1'b1;
            r.load = LOAD_W'(conn_count[w]);
            r.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one beat, waits for the handshake, then records what should come out.
  task automatic issue_cmd(input cmd_t cmd, input logic [WORKER_W-1:0] w);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.worker  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(balance_step(cmd, w));
    items_sent++;
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WORKER_COUNT) wc_cfg = val[WC_W-1:0];
    else cap_cfg = val[CAP_W-1:0];
  endtask

  task automatic test_reset_defaults();
    sender_idle_pct = 0;
    rcv_stall_pct = 0;
    issue_cmd(CMD_PICK, 4'd0);
    issue_cmd(CMD_CLOSE, 4'd0);
    issue_cmd(CMD_ACCEPT, 4'd0);
    issue_cmd(CMD_ACCEPT, 4'd15);
    issue_cmd(CMD_ACCEPT, 4'd5);
    issue_cmd(CMD_PICK, 4'd15);
    issue_cmd(CMD_RSVD, 4'd15);
    issue_cmd(CMD_RSVD, 4'd0);
    issue_cmd(CMD_CLOSE, 4'd15);
    issue_cmd(CMD_CLOSE, 4'd15);
    issue_cmd(CMD_PICK, 4'd10);
  endtask

  task automatic test_worker_count_limits();
    wait_results_done();
    // zero behaves as a single worker
    write_reg(REG_WORKER_COUNT, 32'hFFFF_FFE0);
    issue_cmd(CMD_ACCEPT, 4'd0);
    issue_cmd(CMD_ACCEPT, 4'd1);
    issue_cmd(CMD_CLOSE, 4'd15);
    issue_cmd(CMD_PICK, 4'd7);
    wait_results_done();
    // 31 clamps to all sixteen workers
    write_reg(REG_WORKER_COUNT, 32'hFFFF_FFFF);
    issue_cmd(CMD_ACCEPT, 4'd15);
    issue_cmd(CMD_PICK, 4'd0);
  endtask

  task automatic test_capacity_extremes();
    wait_results_done();
    write_reg(REG_CAPACITY, 32'd0);
    issue_cmd(CMD_PICK, 4'd3);
    wait_results_done();
    write_reg(REG_CAPACITY, 32'd1);
    write_reg(REG_WORKER_COUNT, 32'd2);
    issue_cmd(CMD_ACCEPT, 4'd1);
    issue_cmd(CMD_PICK, 4'd0);
    wait_results_done();
    write_reg(REG_CAPACITY, 32'hFFFF_FFFF);
    write_reg(REG_WORKER_COUNT, 32'd16);
    issue_cmd(CMD_PICK, 4'd9);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int sel;
    int r;
    int eff;
    logic [WC_W-1:0] wc;
    logic [CAP_W-1:0] cap;
    cmd_t cmd;
    logic [WORKER_W-1:0] w;
    sender_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    for (int sub = 0; sub < 2; sub++) begin
      wait_results_done();
      sel = $urandom_range(4);
      if (sel == 0) wc = 5'd0;
      else if (sel == 1) wc = 5'd1;
      else if (sel == 2) wc = 5'd16;
      else if (sel == 3) wc = 5'd31;
      else wc = WC_W'($urandom_range(31));
      write_reg(REG_WORKER_COUNT, ($urandom() & ~32'h1F) | CFG_W'(wc));
      sel = $urandom_range(5);
      if (sel == 0) cap = '0;
      else if (sel == 1) cap = 32'd1;
      else if (sel == 2) cap = $urandom_range(8, 2);
      else if (sel == 3) cap = $urandom_range(300, 9);
      else if (sel == 4) cap = 32'hFFFF_FFFF;
      else cap = $urandom();
      write_reg(REG_CAPACITY, cap);
      eff = active_workers();
      for (int k = 0; k < n_items / 2; k++) begin
        r = $urandom_range(99);
        if (r < 35) cmd = CMD_PICK;
        else if (r < 72) cmd = CMD_ACCEPT;
        else if (r < 95) cmd = CMD_CLOSE;
        else cmd = CMD_RSVD;
        if (cmd == CMD_PICK || $urandom_range(9) >= 8) w = WORKER_W'($urandom_range(15));
        else w = WORKER_W'($urandom_range(eff - 1));
        issue_cmd(cmd, w);
      end
    end
  endtask

  // Result side held off while beats keep coming, so the input must stall.
  task automatic test_backpressure();
    wait_results_done();
    sender_idle_pct = 0;
    rcv_stall_pct = 0;
    write_reg(REG_WORKER_COUNT, 32'd16);
    hold_len = 300;
    hold_req++;
    for (int k = 0; k < 24; k++) begin
      issue_cmd(($urandom_range(1) != 0) ? CMD_ACCEPT : CMD_PICK,
                WORKER_W'($urandom_range(15)));
    end
    wait_results_done();
  endtask

  // A run of accepts on one worker, then a close, another accept and a pick.
  task automatic test_accept_run();
    wait_results_done();
    sender_idle_pct = 0;
    rcv_stall_pct = 0;
    write_reg(REG_WORKER_COUNT, 32'd16);
    write_reg(REG_CAPACITY, 32'd20);
    for (int k = 0; k < 20; k++) issue_cmd(CMD_ACCEPT, 4'd3);
    issue_cmd(CMD_CLOSE, 4'd3);
    issue_cmd(CMD_ACCEPT, 4'd3);
    issue_cmd(CMD_PICK, 4'd0);
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= hold_len - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result target=%0d load=%0d status=%0d", $time,
                 out_ch.target_worker, out_ch.load, out_ch.status);
        errors++;
      end else begin
        head = pending_results.pop_front();
        results_checked++;
        if (out_ch.target_worker !== head.target) begin
          $display("%0t: target_worker expected %0d got %0d", $time, head.target,
                   out_ch.target_worker);
          errors++;
        end
        if (out_ch.load !== head.load) begin
          $display("%0t: load expected %0d got %0d", $time, head.load, out_ch.load);
          errors++;
        end
        if (out_ch.status !== head.status) begin
          $display("%0t: status expected %0d got %0d", $time, head.status,
                   out_ch.status);
          errors++;
        end
        if (head.status == ST_FULL) full_seen++;
        if (head.status == ST_RANGE) range_seen++;
        if (head.status == ST_IDLE_CLOSE) idle_close_seen++;
        if (head.status == ST_OK && head.load == LOAD_W'(COUNT_TOP)) saturated_seen++;
      end
    end
  end

  // Watchdog: too long without any beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WORKER_COUNT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_PICK;
    in_ch.worker = '0;
    for (int i = 0; i < MAX_W; i++) conn_count[i] = '0;
    wc_cfg = WC_RESET;
    cap_cfg = CAP_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_worker_count_limits();
    test_capacity_extremes();
    test_random_traffic(0, 0, 90);
    test_random_traffic(75, 0, 90);
    test_random_traffic(0, 75, 90);
    test_random_traffic(21, 21, 100);
    test_backpressure();
    test_accept_run();
    wait_results_done();
    repeat (30) @(posedge clk);

    $display("Sent %0d commands, checked %0d results under mixed idle and stall patterns.",
             items_sent, results_checked);
    $display("Saw %0d full picks, %0d range errors, %0d idle closes, %0d saturated accepts.",
             full_seen, range_seen, idle_close_seen, saturated_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
